### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the event queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

### rtl/mrcq_pkg.sv
// ----------------------------------------------------------------------------
// mrcq_pkg
// Types, codes and helper functions of the mouse report coalescing queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrcq_pkg;

	localparam int QUEUE_DEPTH_DEF    = 8;
	localparam int INTERVAL_W         = 10;
	localparam int FLUSH_INTERVAL_RST = 10;
	localparam int TICKS_W            = 16;

	localparam logic [1:0] REQ_REPORT = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_POP    = 2'd2;

	localparam logic [1:0] ST_DOWN = 2'd0;
	localparam logic [1:0] ST_UP   = 2'd1;
	localparam logic [1:0] ST_MOVE = 2'd2;

	localparam logic [2:0] BTN_NONE        = 3'd0;
	localparam logic [2:0] BTN_LEFT        = 3'd1;
	localparam logic [2:0] BTN_RIGHT       = 3'd2;
	localparam logic [2:0] BTN_MIDDLE      = 3'd3;
	localparam logic [2:0] BTN_SCROLL_UP   = 3'd4;
	localparam logic [2:0] BTN_SCROLL_DOWN = 3'd5;

	localparam logic [7:0] MASK_LEFT   = 8'h01;
	localparam logic [7:0] MASK_RIGHT  = 8'h02;
	localparam logic [7:0] MASK_MIDDLE = 8'h04;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [7:0]        report_buttons;
		logic signed [7:0] report_dx;
		logic signed [7:0] report_dy;
		logic signed [7:0] report_wheel;
	} req_word_t;

	typedef struct packed {
		logic               event_valid;
		logic [1:0]         event_state;
		logic [2:0]         event_button;
		logic signed [15:0] event_dx;
		logic signed [15:0] event_dy;
		logic [3:0]         queued_events;
	} rsp_word_t;

	typedef struct packed {
		logic [1:0]         state;
		logic [2:0]         button;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	function automatic logic signed [31:0] sat_add32(logic signed [31:0] a,
			logic signed [7:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {{25{b[7]}}, b};
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return s[31:0];
	endfunction

	function automatic logic signed [15:0] clamp16(logic signed [31:0] v);
		if (v > 32'sd32767) begin
			return 16'sh7FFF;
		end
		if (v < -32'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic [2:0] mask_to_button(logic [7:0] m);
		if ((m & MASK_LEFT) != 8'h00) begin
			return BTN_LEFT;
		end
		if ((m & MASK_RIGHT) != 8'h00) begin
			return BTN_RIGHT;
		end
		if ((m & MASK_MIDDLE) != 8'h00) begin
			return BTN_MIDDLE;
		end
		return BTN_NONE;
	endfunction

endpackage

`default_nettype wire

### rtl/mouse_report_coalescing_queue_core.sv
// ----------------------------------------------------------------------------
// mouse_report_coalescing_queue_core
// Coalesces boot-mouse reports into a short queue of pointer events held in a
// row of shifting cells, with eviction of move and scroll events when full.
// ----------------------------------------------------------------------------
//  channel | signals                    | direction | word
//  config  | cfg_we, cfg_data           | in        | flush interval in ticks
//  request | req_valid, req_stall       | in        | req_word_t
//  result  | rsp_valid, rsp_stall       | out       | rsp_word_t, one per request
//
// A pop, a tick with nothing due or an unknown request goes from decode to the
// result, and a report without a button change passes the wheel step as well.
// A button change or a due tick flushes through the push state, up to three
// event writes. Each write into a full queue scans the cells one per cycle.
// Reset clears the count, the pending sums and the interval to its default.
// A new request is taken while the previous result still waits under stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mouse_report_coalescing_queue_core #(
	parameter int QUEUE_DEPTH = mrcq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mrcq_pkg::INTERVAL_W-1:0]     cfg_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  mrcq_pkg::req_word_t                 req_data,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output mrcq_pkg::rsp_word_t                 rsp_data
);
	import mrcq_pkg::*;

	localparam int IDXW = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FLUSH_MOVE, S_FLUSH_SCROLL, S_FLUSH_CLEAR,
		S_WHEEL, S_PUSH, S_SCAN, S_EVICT, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE, OP_PUSH, OP_REMOVE, OP_REPLACE
	} op_t;

	state_t                   state_q, ret_q;
	req_word_t                req_q;
	rsp_word_t                res_q, rsp_q;
	rsp_word_t                rsp_next;
	logic                     rsp_valid_q;
	logic [CNTW-1:0]          cnt_q;
	logic [7:0]               prev_q;
	logic signed [31:0]       px_q, py_q, ps_q;
	logic [TICKS_W-1:0]       ticks_q;
	logic [INTERVAL_W-1:0]    interval_q;
	entry_t                   push_q, btn_ev_q;
	logic                     do_btn_q;
	logic [IDXW-1:0]          idx_q, plain_idx_q, move_idx_q;
	logic                     plain_found_q, move_found_q;

	op_t                      op;
	logic [IDXW-1:0]          op_pos;
	entry_t                   cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   plain_vec, move_vec;

	logic [7:0]               pressed, released;
	logic [TICKS_W-1:0]       ticks_inc;
	logic                     pending_any;
	logic                     rsp_free;
	logic [31:0]              cnt_ext;

	assign pressed     = req_q.report_buttons & ~prev_q;
	assign released    = prev_q & ~req_q.report_buttons;
	assign ticks_inc   = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
	assign pending_any = (px_q != 0) || (py_q != 0) || (ps_q != 0);
	assign rsp_free    = !rsp_valid_q || !rsp_stall;
	assign cnt_ext     = 32'(cnt_q);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		rsp_next               = res_q;
		rsp_next.queued_events = (cnt_ext > 32'd15) ? 4'd15 : cnt_ext[3:0];
	end

	always_comb begin
		op     = OP_NONE;
		op_pos = '0;
		unique case (state_q)
			S_DECODE: begin
				if (req_q.req_type == REQ_POP && cnt_q != '0) begin
					op = OP_REMOVE;
				end
			end
			S_PUSH: begin
				if (cnt_q < CNTW'(QUEUE_DEPTH)) begin
					op     = OP_PUSH;
					op_pos = cnt_q[IDXW-1:0];
				end
			end
			S_EVICT: begin
				if (plain_found_q) begin
					op     = OP_REPLACE;
					op_pos = plain_idx_q;
				end else if (move_found_q) begin
					op     = OP_REPLACE;
					op_pos = move_idx_q;
				end
			end
			default: begin
				op = OP_NONE;
			end
		endcase
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    next_entry;

		assign ctl.load  = (op == OP_PUSH && op_pos == IDXW'(i)) ||
			(op == OP_REPLACE && i == QUEUE_DEPTH - 1);
		assign ctl.shift = (op == OP_REMOVE || op == OP_REPLACE) && (IDXW'(i) >= op_pos);

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_entry = cell_entry[i];
		end else begin : g_mid
			assign next_entry = cell_entry[i + 1];
		end

		mrcq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_entry  (push_q),
			.next_entry (next_entry),
			.entry      (cell_entry[i]),
			.is_plain   (plain_vec[i]),
			.is_move    (move_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ret_q         <= S_IDLE;
			rsp_valid_q   <= 1'b0;
			cnt_q         <= '0;
			prev_q        <= '0;
			px_q          <= '0;
			py_q          <= '0;
			ps_q          <= '0;
			ticks_q       <= '0;
			interval_q    <= INTERVAL_W'(FLUSH_INTERVAL_RST);
			do_btn_q      <= 1'b0;
			plain_found_q <= 1'b0;
			move_found_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_data;
			end
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q    <= req_data;
						res_q    <= '0;
						do_btn_q <= 1'b0;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (req_q.req_type)
						REQ_REPORT: begin
							prev_q <= req_q.report_buttons;
							if (pressed != 8'h00 || released != 8'h00) begin
								do_btn_q        <= 1'b1;
								btn_ev_q.state  <= (pressed != 8'h00) ? ST_DOWN : ST_UP;
								btn_ev_q.button <= mask_to_button(
									(pressed != 8'h00) ? pressed : released);
								btn_ev_q.dx     <= {{8{req_q.report_dx[7]}}, req_q.report_dx};
								btn_ev_q.dy     <= {{8{req_q.report_dy[7]}}, req_q.report_dy};
								state_q         <= S_FLUSH_MOVE;
							end else begin
								if (req_q.report_dx != 0 || req_q.report_dy != 0) begin
									px_q <= sat_add32(px_q, req_q.report_dx);
									py_q <= sat_add32(py_q, req_q.report_dy);
								end
								state_q <= S_WHEEL;
							end
						end
						REQ_TICK: begin
							ticks_q <= ticks_inc;
							if (pending_any && ticks_inc >= TICKS_W'(interval_q)) begin
								state_q <= S_FLUSH_MOVE;
							end else begin
								state_q <= S_DONE;
							end
						end
						REQ_POP: begin
							if (cnt_q != '0) begin
								res_q.event_valid  <= 1'b1;
								res_q.event_state  <= cell_entry[0].state;
								res_q.event_button <= cell_entry[0].button;
								res_q.event_dx     <= cell_entry[0].dx;
								res_q.event_dy     <= cell_entry[0].dy;
								cnt_q              <= cnt_q - 1'b1;
							end
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_FLUSH_MOVE: begin
					if (px_q != 0 || py_q != 0) begin
						push_q  <= '{state: ST_MOVE, button: BTN_NONE,
							dx: clamp16(px_q), dy: clamp16(py_q)};
						ret_q   <= S_FLUSH_SCROLL;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_FLUSH_SCROLL;
					end
				end
				S_FLUSH_SCROLL: begin
					if (ps_q != 0) begin
						push_q  <= '{state: ST_MOVE,
							button: ps_q[31] ? BTN_SCROLL_DOWN : BTN_SCROLL_UP,
							dx: 16'sd0, dy: 16'sd0};
						ret_q   <= S_FLUSH_CLEAR;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_FLUSH_CLEAR;
					end
				end
				S_FLUSH_CLEAR: begin
					px_q    <= '0;
					py_q    <= '0;
					ps_q    <= '0;
					ticks_q <= '0;
					if (do_btn_q) begin
						push_q  <= btn_ev_q;
						ret_q   <= S_WHEEL;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_WHEEL;
					end
				end
				S_WHEEL: begin
					if (req_q.req_type == REQ_REPORT && req_q.report_wheel != 0) begin
						ps_q <= sat_add32(ps_q, req_q.report_wheel);
					end
					state_q <= S_DONE;
				end
				S_PUSH: begin
					if (cnt_q < CNTW'(QUEUE_DEPTH)) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ret_q;
					end else begin
						idx_q         <= '0;
						plain_found_q <= 1'b0;
						move_found_q  <= 1'b0;
						state_q       <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (plain_vec[idx_q] && !plain_found_q) begin
						plain_found_q <= 1'b1;
						plain_idx_q   <= idx_q;
					end
					if (move_vec[idx_q] && !move_found_q) begin
						move_found_q <= 1'b1;
						move_idx_q   <= idx_q;
					end
					if (idx_q == IDXW'(QUEUE_DEPTH - 1)) begin
						state_q <= S_EVICT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EVICT: begin
					state_q <= ret_q;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q   <= rsp_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, cnt_q <= CNTW'(QUEUE_DEPTH))
	`ASSERT_SAME(a_evict_when_full, clk, arst_n, op == OP_REPLACE, cnt_q == CNTW'(QUEUE_DEPTH))
	`ASSERT_NEXT(a_pop_decrements, clk, arst_n,
		state_q == S_DECODE && req_q.req_type == REQ_POP && cnt_q != '0,
		cnt_q == $past(cnt_q) - 1'b1)

endmodule

`default_nettype wire

### rtl/mrcq_cell.sv
// ----------------------------------------------------------------------------
// mrcq_cell
// One queue slot: loads a new event or takes its neighbor's event on a shift,
// and flags whether it holds a plain move or any move event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrcq_cell (
	input  logic               clk,
	input  mrcq_pkg::cell_ctl_t ctl,
	input  mrcq_pkg::entry_t   new_entry,
	input  mrcq_pkg::entry_t   next_entry,
	output mrcq_pkg::entry_t   entry,
	output logic               is_plain,
	output logic               is_move
);
	import mrcq_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= new_entry;
		end else if (ctl.shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry    = entry_q;
	assign is_move  = (entry_q.state == ST_MOVE);
	assign is_plain = (entry_q.state == ST_MOVE) && (entry_q.button == BTN_NONE);

endmodule

`default_nettype wire

### dv/event_queue_checker.sv
// ----------------------------------------------------------------------------
// event_queue_checker
// Watches the request, result and register ports of the mouse event queue.
// It keeps its own copy of the queue, the pending sums and the tick age.
// It works out the result word for every accepted request and compares each
// accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module event_queue_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mrcq_pkg::INTERVAL_W-1:0] cfg_data,
	input  logic                            req_valid,
	input  logic                            req_stall,
	input  mrcq_pkg::req_word_t             req_data,
	input  logic                            rsp_valid,
	input  logic                            rsp_stall,
	input  mrcq_pkg::rsp_word_t             rsp_data,
	output int                              fault_count,
	output int                              owed_count,
	output int                              req_count,
	output int                              popped_count,
	output int                              flush_count,
	output int                              evict_count,
	output int                              refuse_count
);

	import mrcq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int REPORT_LIMIT = 10;

	entry_t                         event_fifo[$];
	rsp_word_t                      owed_words[$];
	logic [7:0]                     last_buttons;
	logic signed [31:0]             sum_x;
	logic signed [31:0]             sum_y;
	logic signed [31:0]             sum_wheel;
	logic [TICKS_W-1:0]             tick_age;
	logic [INTERVAL_W-1:0]          interval;
	int                             n_fault;
	int                             n_req;
	int                             n_popped;
	int                             n_flush;
	int                             n_evict;
	int                             n_refuse;

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (s < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return s[31:0];
	endfunction

	function automatic logic signed [15:0] narrow16(input logic signed [31:0] v);
		if (v > 32'sd32767) begin
			return 16'sh7FFF;
		end
		if (v < -32'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic [2:0] first_button(input logic [7:0] m);
		if (m[0]) begin
			return BTN_LEFT;
		end
		if (m[1]) begin
			return BTN_RIGHT;
		end
		if (m[2]) begin
			return BTN_MIDDLE;
		end
		return BTN_NONE;
	endfunction

	// A full queue gives up its oldest plain move, then its oldest scroll.
	task automatic store_event(input logic [1:0] st, input logic [2:0] btn,
			input logic signed [15:0] dx, input logic signed [15:0] dy);
		int     victim;
		entry_t e;
		if (event_fifo.size() >= DEPTH) begin
			victim = -1;
			for (int i = 0; i < event_fifo.size(); i++) begin
				if (event_fifo[i].state == ST_MOVE && event_fifo[i].button == BTN_NONE) begin
					victim = i;
					break;
				end
			end
			if (victim < 0) begin
				for (int i = 0; i < event_fifo.size(); i++) begin
					if (event_fifo[i].state == ST_MOVE) begin
						victim = i;
						break;
					end
				end
			end
			if (victim < 0) begin
				n_refuse++;
				return;
			end
			event_fifo.delete(victim);
			n_evict++;
		end
		e.state  = st;
		e.button = btn;
		e.dx     = dx;
		e.dy     = dy;
		event_fifo.push_back(e);
	endtask

	task automatic flush_sums();
		if (sum_x != 0 || sum_y != 0) begin
			store_event(ST_MOVE, BTN_NONE, narrow16(sum_x), narrow16(sum_y));
		end
		if (sum_wheel > 0) begin
			store_event(ST_MOVE, BTN_SCROLL_UP, 16'sd0, 16'sd0);
		end else if (sum_wheel < 0) begin
			store_event(ST_MOVE, BTN_SCROLL_DOWN, 16'sd0, 16'sd0);
		end
		sum_x     = '0;
		sum_y     = '0;
		sum_wheel = '0;
		tick_age  = '0;
		n_flush++;
	endtask

	task automatic coalesce_request(input req_word_t w, output rsp_word_t r);
		logic [7:0]         pressed;
		logic [7:0]         released;
		logic signed [15:0] dx16;
		logic signed [15:0] dy16;
		r        = '0;
		dx16     = {{8{w.report_dx[7]}}, w.report_dx};
		dy16     = {{8{w.report_dy[7]}}, w.report_dy};
		case (w.req_type)
			REQ_REPORT: begin
				pressed      = w.report_buttons & ~last_buttons;
				released     = last_buttons & ~w.report_buttons;
				last_buttons = w.report_buttons;
				if (pressed != 8'h00 || released != 8'h00) begin
					flush_sums();
					if (pressed != 8'h00) begin
						store_event(ST_DOWN, first_button(pressed), dx16, dy16);
					end else begin
						store_event(ST_UP, first_button(released), dx16, dy16);
					end
				end else if (w.report_dx != 8'h00 || w.report_dy != 8'h00) begin
					sum_x = add_sat(sum_x, {{24{w.report_dx[7]}}, w.report_dx});
					sum_y = add_sat(sum_y, {{24{w.report_dy[7]}}, w.report_dy});
				end
				if (w.report_wheel != 8'h00) begin
					sum_wheel = add_sat(sum_wheel, {{24{w.report_wheel[7]}}, w.report_wheel});
				end
			end
			REQ_TICK: begin
				if (tick_age != '1) begin
					tick_age++;
				end
				if ((sum_x != 0 || sum_y != 0 || sum_wheel != 0) && tick_age >= interval) begin
					flush_sums();
				end
			end
			REQ_POP: begin
				if (event_fifo.size() > 0) begin
					r.event_valid  = 1'b1;
					r.event_state  = event_fifo[0].state;
					r.event_button = event_fifo[0].button;
					r.event_dx     = event_fifo[0].dx;
					r.event_dy     = event_fifo[0].dy;
					void'(event_fifo.pop_front());
					n_popped++;
				end
			end
			default: begin
			end
		endcase
		r.queued_events = (event_fifo.size() > 15) ? 4'd15 : 4'(event_fifo.size());
	endtask

	always @(posedge clk) begin : watch
		rsp_word_t want;
		logic      wrong;
		if (!arst_n) begin
			event_fifo.delete();
			owed_words.delete();
			last_buttons = '0;
			sum_x        = '0;
			sum_y        = '0;
			sum_wheel    = '0;
			tick_age     = '0;
			interval     = INTERVAL_W'(FLUSH_INTERVAL_RST);
			n_fault      = 0;
			n_req        = 0;
			n_popped     = 0;
			n_flush      = 0;
			n_evict      = 0;
			n_refuse     = 0;
		end else begin
			if (cfg_we) begin
				interval = cfg_data;
			end
			if (req_valid && !req_stall) begin
				coalesce_request(req_data, want);
				owed_words.push_back(want);
				n_req++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (owed_words.size() == 0) begin
					n_fault++;
					if (n_fault <= REPORT_LIMIT) begin
						$display("%0t: result word with none owed: valid=%0b state=%0d button=%0d",
							$time, rsp_data.event_valid, rsp_data.event_state,
							rsp_data.event_button);
					end
				end else begin
					want  = owed_words.pop_front();
					wrong = (rsp_data.event_valid !== want.event_valid)
						|| (rsp_data.event_state !== want.event_state)
						|| (rsp_data.event_button !== want.event_button)
						|| (rsp_data.event_dx !== want.event_dx)
						|| (rsp_data.event_dy !== want.event_dy)
						|| (rsp_data.queued_events !== want.queued_events);
					if (wrong) begin
						n_fault++;
						if (n_fault <= REPORT_LIMIT) begin
							$display("%0t: expected valid=%0b state=%0d button=%0d dx=%0d dy=%0d queued=%0d",
								$time, want.event_valid, want.event_state, want.event_button,
								want.event_dx, want.event_dy, want.queued_events);
							$display("%0t: actual   valid=%0b state=%0d button=%0d dx=%0d dy=%0d queued=%0d",
								$time, rsp_data.event_valid, rsp_data.event_state,
								rsp_data.event_button, rsp_data.event_dx, rsp_data.event_dy,
								rsp_data.queued_events);
						end
					end
				end
			end
		end
		fault_count  <= n_fault;
		owed_count   <= owed_words.size();
		req_count    <= n_req;
		popped_count <= n_popped;
		flush_count  <= n_flush;
		evict_count  <= n_evict;
		refuse_count <= n_refuse;
	end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the mouse report coalescing queue with a short directed sequence,
// random report, tick and pop words under several flush intervals and a long
// motion drift that hits the 16-bit clamp. Both channels idle at random; the
// checker beside the block judges every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import mrcq_pkg::*;

	localparam logic [1:0] REQ_UNUSED     = 2'd3;
	localparam int         DRAIN_CYCLES   = 48;
	localparam int         WATCHDOG_LIMIT = 5000;
	localparam int         HOLD_CYCLES    = 120;
	localparam int         PHASE_WORDS    = 80;
	localparam int         PHASES         = 8;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [INTERVAL_W-1:0] cfg_data  = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_word_t             req_data  = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_word_t             rsp_data;

	int         fault_count;
	int         owed_count;
	int         req_count;
	int         popped_count;
	int         flush_count;
	int         evict_count;
	int         refuse_count;
	int         burst_left   = 0;
	logic [7:0] held_buttons = '0;

	always #1 clk = ~clk;

	mouse_report_coalescing_queue_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	event_queue_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_data     (req_data),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp_data     (rsp_data),
		.fault_count  (fault_count),
		.owed_count   (owed_count),
		.req_count    (req_count),
		.popped_count (popped_count),
		.flush_count  (flush_count),
		.evict_count  (evict_count),
		.refuse_count (refuse_count)
	);

	function automatic req_word_t report_word(input logic [7:0] b,
			input logic signed [7:0] x, input logic signed [7:0] y,
			input logic signed [7:0] wh);
		req_word_t w;
		w.req_type       = REQ_REPORT;
		w.report_buttons = b;
		w.report_dx      = x;
		w.report_dy      = y;
		w.report_wheel   = wh;
		return w;
	endfunction

	function automatic req_word_t other_word(input logic [1:0] kind);
		req_word_t w;
		w.req_type       = kind;
		w.report_buttons = 8'($urandom);
		w.report_dx      = 8'($urandom);
		w.report_dy      = 8'($urandom);
		w.report_wheel   = 8'($urandom);
		return w;
	endfunction

	function automatic logic signed [7:0] pick_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			return 8'sd0;
		end
		if (r < 30) begin
			return 8'sd127;
		end
		if (r < 35) begin
			return 8'sh80;
		end
		return 8'($urandom);
	endfunction

	function automatic req_word_t random_word(input int pop_pct, input int change_pct);
		int         r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			return other_word(REQ_UNUSED);
		end
		if (r < 2 + pop_pct) begin
			return other_word(REQ_POP);
		end
		if (r < 22 + pop_pct) begin
			return other_word(REQ_TICK);
		end
		b = held_buttons;
		if ($urandom_range(0, 99) < change_pct) begin
			if ($urandom_range(0, 4) == 0) begin
				b = b ^ 8'($urandom_range(1, 255));
			end else begin
				b = b ^ 8'(1 << $urandom_range(0, 2));
			end
		end
		return report_word(b, pick_delta(), pick_delta(),
			($urandom_range(0, 1) == 0) ? 8'sd0 : pick_delta());
	endfunction

	// The sender works in bursts; valid stays high from one word to the next
	// inside a burst and drops only for a gap.
	task automatic send_word(input req_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		if (w.req_type == REQ_REPORT) begin
			held_buttons = w.report_buttons;
		end
		req_valid <= 1'b1;
		req_data  <= w;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (owed_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_interval(input logic [INTERVAL_W-1:0] v);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : receiver
		int mode;
		int left;
		int hold_in;
		int beat;
		mode    = 0;
		left    = 0;
		beat    = 0;
		hold_in = $urandom_range(800, 2000);
		forever begin
			@(posedge clk);
			if (hold_in == 0) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_in = $urandom_range(1500, 3000);
			end else begin
				hold_in--;
				beat++;
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 200);
				end
				left--;
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 99) < 35);
					2: rsp_stall <= (beat % 5 < 2);
					default: rsp_stall <= ($urandom_range(0, 99) < 80);
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("Timeout: no word moved for %0d cycles, %0d results still owed",
			WATCHDOG_LIMIT, owed_count);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		logic [INTERVAL_W-1:0] iv;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset interval: empty pop, unknown request,
		// extreme deltas, press and release priority, buttons outside the
		// three known ones, eviction of moves and scrolls, then a refused event.
		send_word(other_word(REQ_POP));
		send_word(other_word(REQ_UNUSED));
		send_word(report_word(8'h00, 8'sd127, 8'sh80, 8'sd127));
		send_word(report_word(8'h00, 8'sh80, 8'sd127, 8'sh80));
		send_word(report_word(8'h07, -8'sd1, 8'sd1, 8'sd5));
		send_word(report_word(8'h06, 8'sd0, 8'sd0, 8'sd0));
		send_word(report_word(8'h0E, 8'sd3, -8'sd3, 8'sd0));
		send_word(report_word(8'h02, 8'sd0, 8'sd0, 8'sd0));
		send_word(report_word(8'h01, 8'sd127, 8'sd127, 8'sd0));
		send_word(report_word(8'h80, 8'sh80, 8'sh80, 8'sd0));
		send_word(report_word(8'h00, 8'sd0, 8'sd0, 8'sd0));
		send_word(report_word(8'h04, 8'sd0, 8'sd0, 8'sd0));
		send_word(report_word(8'h00, 8'sd0, 8'sd0, 8'sd0));
		repeat (9) send_word(other_word(REQ_POP));
		send_word(other_word(REQ_TICK));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: iv = 10'd1;
				1: iv = 10'd0;
				2: iv = 10'd3;
				3: iv = 10'd1023;
				4: iv = 10'd10;
				5: iv = 10'd1000;
				6: iv = 10'd2;
				default: iv = 10'($urandom_range(1, 1000));
			endcase
			write_interval(iv);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				send_word(random_word((p % 2 == 0) ? 12 : 40, 6 + 4 * p));
			end
		end

		// Motion drift far past the 16-bit range, flushed by a single tick
		// once the interval is zero.
		repeat (9) send_word(other_word(REQ_POP));
		send_word(report_word(held_buttons ^ MASK_LEFT, 8'sd0, 8'sd0, 8'sd0));
		repeat (300) send_word(report_word(held_buttons, 8'sd127, 8'sh80, 8'sd1));
		send_word(other_word(REQ_TICK));
		write_interval(10'd0);
		send_word(other_word(REQ_TICK));
		repeat (9) send_word(other_word(REQ_POP));

		settle();
		$display("Covered %0d request words: %0d events popped, %0d flushes, %0d evictions, %0d refused events.",
			req_count, popped_count, flush_count, evict_count, refuse_count);
		$display("Flush intervals from 0 to 1023 and the 16-bit clamp of the motion sums were reached.");
		if (fault_count == 0 && owed_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d bad result words, %0d still owed", fault_count, owed_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### mouse_report_coalescing_queue_core.f
+incdir+rtl
rtl/mrcq_pkg.sv
rtl/mrcq_cell.sv
rtl/mouse_report_coalescing_queue_core.sv
dv/event_queue_checker.sv
dv/testbench.sv
